// ===== rtl/atcp_pkg.sv =====
// Package for the credential command parser: line kinds, status codes,
// character constants and the hex digit decoder. No dependencies.
package atcp_pkg;

	localparam int POS_W = 6;
	localparam logic [POS_W-1:0] POS_MAX = 6'd63;
	localparam logic [POS_W-1:0] POS_DIGITS = 6'd5;
	localparam logic [POS_W-1:0] POS_LEN16 = 6'd21;
	localparam logic [POS_W-1:0] POS_LEN32 = 6'd37;

	localparam logic [7:0] CH_NL = 8'd10;
	localparam logic [7:0] CH_A = 8'h41;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_QM = 8'h3F;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_D = 8'h44;
	localparam logic [7:0] CH_K = 8'h4B;
	localparam logic [7:0] CH_S = 8'h53;
	localparam logic [7:0] CH_EQ = 8'h3D;

	typedef enum logic [2:0] {
		KIND_START = 3'd0,
		KIND_HELP = 3'd1,
		KIND_DEV = 3'd2,
		KIND_APP = 3'd3,
		KIND_KEY = 3'd4,
		KIND_SAVE = 3'd5,
		KIND_NONE = 3'd7
	} line_kind_t;

	typedef enum logic [3:0] {
		ST_HELP = 4'd0,
		ST_DEV_OK = 4'd1,
		ST_DEV_BAD = 4'd2,
		ST_APP_OK = 4'd3,
		ST_APP_BAD = 4'd4,
		ST_KEY_OK = 4'd5,
		ST_KEY_BAD = 4'd6,
		ST_SAVED = 4'd7,
		ST_INCOMPLETE = 4'd8,
		ST_INVALID = 4'd9
	} status_t;

	// Current line as seen by the finishing logic
	typedef struct packed {
		logic [POS_W-1:0] pos;
		line_kind_t kind;
		logic all_hex;
		logic [63:0] shift_hi;
		logic [63:0] shift_lo;
	} line_info_t;

	// Returns {is_hex, nibble}
	function automatic logic [4:0] hex_decode(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

// ===== rtl/atcp_line_scan.sv =====
// Line scanner: tracks position, prefix match and the hex digit shifter.
// Depends on atcp_pkg.
module atcp_line_scan (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic [7:0] in_byte,
	output atcp_pkg::line_info_t info
);
	import atcp_pkg::*;

	logic [POS_W-1:0] pos_q, pos_d;
	line_kind_t kind_q, kind_d;
	logic all_hex_q, all_hex_d;
	logic [63:0] hi_q, hi_d, lo_q, lo_d;
	logic [4:0] hx;

	assign hx = hex_decode(in_byte);

	// Next line state for one item
	always_comb begin
		pos_d = pos_q;
		kind_d = kind_q;
		all_hex_d = all_hex_q;
		hi_d = hi_q;
		lo_d = lo_q;
		if (in_byte == CH_NL) begin
			pos_d = '0;
			kind_d = KIND_START;
			all_hex_d = 1'b1;
			hi_d = '0;
			lo_d = '0;
		end else begin
			if (pos_q < POS_DIGITS) begin
				case (kind_q)
					KIND_START: begin
						if (pos_q == 6'd0) begin
							if (in_byte != CH_A) kind_d = KIND_NONE;
						end else if (pos_q == 6'd1) begin
							if (in_byte != CH_T) kind_d = KIND_NONE;
						end else if (pos_q == 6'd2) begin
							if (in_byte == CH_QM) kind_d = KIND_HELP;
							else if (in_byte != CH_PLUS) kind_d = KIND_NONE;
						end else begin
							if (in_byte == CH_D) kind_d = KIND_DEV;
							else if (in_byte == CH_A) kind_d = KIND_APP;
							else if (in_byte == CH_K) kind_d = KIND_KEY;
							else if (in_byte == CH_S) kind_d = KIND_SAVE;
							else kind_d = KIND_NONE;
						end
					end
					KIND_HELP, KIND_SAVE: kind_d = KIND_NONE;
					KIND_DEV: begin
						if (pos_q == 6'd4 && in_byte != CH_EQ) kind_d = KIND_NONE;
					end
					default: kind_d = kind_q;
				endcase
			end else if (!hx[4]) begin
				all_hex_d = 1'b0;
			end else begin
				hi_d = {hi_q[59:0], lo_q[63:60]};
				lo_d = {lo_q[59:0], hx[3:0]};
			end
			if (pos_q < POS_MAX) pos_d = pos_q + 6'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			kind_q <= KIND_START;
			all_hex_q <= 1'b1;
			hi_q <= '0;
			lo_q <= '0;
		end else if (step) begin
			pos_q <= pos_d;
			kind_q <= kind_d;
			all_hex_q <= all_hex_d;
			hi_q <= hi_d;
			lo_q <= lo_d;
		end
	end

	assign info = '{pos: pos_q, kind: kind_q, all_hex: all_hex_q,
		shift_hi: hi_q, shift_lo: lo_q};

endmodule

// ===== rtl/atcp_cred_store.sv =====
// Credential store: classifies a finished line, updates the stores and
// the held and configured flags. Depends on atcp_pkg.
module atcp_cred_store (
	input logic clk,
	input logic arst_n,
	input logic finish,
	input atcp_pkg::line_info_t info,
	output atcp_pkg::status_t status,
	output logic configured,
	output logic [63:0] dev_eui,
	output logic [63:0] app_eui,
	output logic [63:0] app_key_hi,
	output logic [63:0] app_key_lo
);
	import atcp_pkg::*;

	logic [2:0] held_q;
	logic done_q;
	logic [63:0] dev_q, app_q, key_hi_q, key_lo_q;
	logic ok16, ok32;
	logic wr_dev, wr_app, wr_key, wr_done;

	assign ok16 = (info.pos == POS_LEN16) && info.all_hex;
	assign ok32 = (info.pos == POS_LEN32) && info.all_hex;

	// Line classification
	always_comb begin
		status = ST_INVALID;
		wr_dev = 1'b0;
		wr_app = 1'b0;
		wr_key = 1'b0;
		wr_done = 1'b0;
		unique case (info.kind)
			KIND_HELP: status = ST_HELP;
			KIND_DEV: begin
				if (info.pos < POS_DIGITS) status = ST_INVALID;
				else if (ok16) begin
					status = ST_DEV_OK;
					wr_dev = 1'b1;
				end else status = ST_DEV_BAD;
			end
			KIND_APP: begin
				status = ok16 ? ST_APP_OK : ST_APP_BAD;
				wr_app = ok16;
			end
			KIND_KEY: begin
				status = ok32 ? ST_KEY_OK : ST_KEY_BAD;
				wr_key = ok32;
			end
			KIND_SAVE: begin
				status = (held_q == 3'b111) ? ST_SAVED : ST_INCOMPLETE;
				wr_done = (held_q == 3'b111);
			end
			default: status = ST_INVALID;
		endcase
	end

	// Flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			done_q <= 1'b0;
		end else if (finish) begin
			held_q <= held_q | {wr_key, wr_app, wr_dev};
			if (wr_done) done_q <= 1'b1;
		end
	end

	// Stored values, zero until written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_q <= '0;
			app_q <= '0;
			key_hi_q <= '0;
			key_lo_q <= '0;
		end else if (finish) begin
			if (wr_dev) dev_q <= info.shift_lo;
			if (wr_app) app_q <= info.shift_lo;
			if (wr_key) begin
				key_hi_q <= info.shift_hi;
				key_lo_q <= info.shift_lo;
			end
		end
	end

	assign configured = done_q;
	assign dev_eui = dev_q;
	assign app_eui = app_q;
	assign app_key_hi = key_hi_q;
	assign app_key_lo = key_lo_q;

endmodule

// ===== rtl/at_credential_command_parser.sv =====
// Top level of the credential command parser: input register, line
// scanner, credential store and result register. Depends on atcp_pkg.
// A newline passes from the input register into the result register, where its
// status item is held valid until it is taken.
// Throughput: one character per cycle; a newline waits in the input
// register only while a previous status is still stalled at the output.
// Reset (arst_n low, asynchronous) clears the line, the stores and flags.
module at_credential_command_parser (
	input logic clk,
	input logic arst_n,
	input logic byte_valid,
	output logic byte_stall,
	input logic [7:0] in_byte,
	output logic result_valid,
	input logic result_stall,
	output logic [3:0] status,
	output logic configured,
	output logic [63:0] dev_eui,
	output logic [63:0] app_eui,
	output logic [63:0] app_key_hi,
	output logic [63:0] app_key_lo
);
	import atcp_pkg::*;

	logic valid_s1;
	logic [7:0] byte_s1;
	logic adv, fin, accept;
	logic out_valid_q;
	status_t status_d;
	logic [3:0] status_q;
	line_info_t info;

	// A newline needs a free result register; other characters always move
	assign adv = valid_s1 && (byte_s1 != CH_NL || !out_valid_q || !result_stall);
	assign fin = adv && byte_s1 == CH_NL;
	assign byte_stall = valid_s1 && !adv;
	assign accept = byte_valid && !byte_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) byte_s1 <= in_byte;
	end

	atcp_line_scan u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.step(adv),
		.in_byte(byte_s1),
		.info(info)
	);

	atcp_cred_store u_store (
		.clk(clk),
		.arst_n(arst_n),
		.finish(fin),
		.info(info),
		.status(status_d),
		.configured(configured),
		.dev_eui(dev_eui),
		.app_eui(app_eui),
		.app_key_hi(app_key_hi),
		.app_key_lo(app_key_lo)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) status_q <= status_d;
	end

	assign result_valid = out_valid_q;
	assign status = status_q;

endmodule

// ===== verif/atcp_checker.sv =====
`timescale 1ns / 1ps
// Checker for the credential command parser: predicts the status item of each line
// from the accepted characters and compares every accepted result item. Uses atcp_pkg.
module atcp_checker (
	input logic clk,
	input logic arst_n,
	input logic byte_valid,
	input logic byte_stall,
	input logic [7:0] in_byte,
	input logic result_valid,
	input logic result_stall,
	input logic [3:0] status,
	input logic configured,
	input logic [63:0] dev_eui,
	input logic [63:0] app_eui,
	input logic [63:0] app_key_hi,
	input logic [63:0] app_key_lo,
	output int mismatches,
	output int pending
);
	import atcp_pkg::*;

	typedef struct {
		status_t st;
		logic cfg;
		logic [63:0] dev;
		logic [63:0] app;
		logic [127:0] key;
	} reply_t;

	reply_t awaited_replies[$];
	int fail_count;

	// Line being scanned
	logic [POS_W-1:0] line_pos;
	line_kind_t kind;
	logic all_hex;
	logic [127:0] digits;

	// Stored credentials and flags
	logic [63:0] dev_val;
	logic [63:0] app_val;
	logic [127:0] key_val;
	logic [2:0] held;
	logic cfg_done;

	// Value of a hex character, -1 for anything else
	function automatic int nibble_of(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - int'("0");
		if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
		if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
		return -1;
	endfunction

	task automatic clear_line();
		line_pos = '0;
		kind = KIND_START;
		all_hex = 1'b1;
		digits = '0;
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
		input logic [63:0] got);
		if (want !== got) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
		end
	endtask

	// Advance the predicted parser by one character
	task automatic parse_char(input logic [7:0] c);
		reply_t r;
		status_t st;
		int d;
		if (c == CH_NL) begin
			// newline: classify the line and apply its store
			case (kind)
				KIND_HELP: st = ST_HELP;
				KIND_DEV: begin
					if (line_pos < POS_DIGITS) begin
						st = ST_INVALID;
					end else if (line_pos == POS_LEN16 && all_hex) begin
						dev_val = digits[63:0];
						held[0] = 1'b1;
						st = ST_DEV_OK;
					end else begin
						st = ST_DEV_BAD;
					end
				end
				KIND_APP: begin
					if (line_pos == POS_LEN16 && all_hex) begin
						app_val = digits[63:0];
						held[1] = 1'b1;
						st = ST_APP_OK;
					end else begin
						st = ST_APP_BAD;
					end
				end
				KIND_KEY: begin
					if (line_pos == POS_LEN32 && all_hex) begin
						key_val = digits;
						held[2] = 1'b1;
						st = ST_KEY_OK;
					end else begin
						st = ST_KEY_BAD;
					end
				end
				KIND_SAVE: begin
					if (&held) begin
						cfg_done = 1'b1;
						st = ST_SAVED;
					end else begin
						st = ST_INCOMPLETE;
					end
				end
				default: st = ST_INVALID;
			endcase
			r.st = st;
			r.cfg = cfg_done;
			r.dev = dev_val;
			r.app = app_val;
			r.key = key_val;
			awaited_replies.push_back(r);
			clear_line();
		end else begin
			if (line_pos < POS_DIGITS) begin
				// prefix matching
				case (kind)
					KIND_START: begin
						case (line_pos)
							0: if (c != CH_A) kind = KIND_NONE;
							1: if (c != CH_T) kind = KIND_NONE;
							2: begin
								if (c == CH_QM) kind = KIND_HELP;
								else if (c != CH_PLUS) kind = KIND_NONE;
							end
							default: begin
								if (c == CH_D) kind = KIND_DEV;
								else if (c == CH_A) kind = KIND_APP;
								else if (c == CH_K) kind = KIND_KEY;
								else if (c == CH_S) kind = KIND_SAVE;
								else kind = KIND_NONE;
							end
						endcase
					end
					KIND_HELP, KIND_SAVE: kind = KIND_NONE;
					KIND_DEV: if (line_pos == POS_DIGITS - 1 && c != CH_EQ) kind = KIND_NONE;
					default: ;
				endcase
			end else begin
				// digit field
				d = nibble_of(c);
				if (d < 0) all_hex = 1'b0;
				else digits = {digits[123:0], d[3:0]};
			end
			if (line_pos != POS_MAX) line_pos++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			clear_line();
			dev_val = '0;
			app_val = '0;
			key_val = '0;
			held = '0;
			cfg_done = 1'b0;
			awaited_replies.delete();
			fail_count = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			// compare before predicting: a result never follows its newline in the same cycle
			if (result_valid && !result_stall) begin
				if (awaited_replies.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: result item with none expected, status %0d",
							$realtime, status);
				end else begin
					want = awaited_replies.pop_front();
					check_field("status", 64'(want.st), 64'(status));
					check_field("configured", 64'(want.cfg), 64'(configured));
					check_field("dev_eui", want.dev, dev_eui);
					check_field("app_eui", want.app, app_eui);
					check_field("app_key_hi", want.key[127:64], app_key_hi);
					check_field("app_key_lo", want.key[63:0], app_key_lo);
				end
			end
			if (byte_valid && !byte_stall)
				parse_char(in_byte);
			mismatches <= fail_count;
			pending <= awaited_replies.size();
		end
	end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench top for the credential command parser: sends directed and random command
// lines with random idling on both sides. Depends on atcp_pkg, atcp_checker and the RTL.
module tb_top;
	import atcp_pkg::*;

	// Random part sized so that directed plus random lines come to about 1650 items
	localparam int RANDOM_CHARS = 1380;
	localparam int QUIET_TAIL = 200;
	localparam int CYCLE_LIMIT = 200000;

	typedef enum int {CRED_DEV, CRED_APP, CRED_KEY} cred_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic byte_valid = 1'b0;
	logic byte_stall;
	logic [7:0] in_byte = 8'd0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic [3:0] status;
	logic configured;
	logic [63:0] dev_eui;
	logic [63:0] app_eui;
	logic [63:0] app_key_hi;
	logic [63:0] app_key_lo;
	int mismatches;
	int pending;

	logic idling_on = 1'b1;
	int sent_chars = 0;
	int cycles = 0;
	logic [7:0] line_buf[$];

	at_credential_command_parser dut (
		.clk, .arst_n, .byte_valid, .byte_stall, .in_byte,
		.result_valid, .result_stall, .status, .configured,
		.dev_eui, .app_eui, .app_key_hi, .app_key_lo
	);

	atcp_checker chk (
		.clk, .arst_n, .byte_valid, .byte_stall, .in_byte,
		.result_valid, .result_stall, .status, .configured,
		.dev_eui, .app_eui, .app_key_hi, .app_key_lo,
		.mismatches, .pending
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	// Result side stall bursts
	initial begin
		forever begin
			@(posedge clk);
			if (idling_on && arst_n && $urandom_range(0, 5) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// Any character except newline
	function automatic logic [7:0] any_char();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == CH_NL) b = CH_EQ;
		return b;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10) return "0" + {4'd0, v};
		if ($urandom_range(0, 1)) return "A" + {4'd0, v} - 8'd10;
		return "a" + {4'd0, v} - 8'd10;
	endfunction

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
	endtask

	task automatic add_hex(input int n);
		for (int i = 0; i < n; i++) line_buf.push_back(hex_char(4'($urandom_range(0, 15))));
	endtask

	task automatic add_cred(input cred_t which, input int ndigits);
		case (which)
			CRED_DEV: add_text("AT+D=");
			CRED_APP: begin
				add_text("AT+A");
				line_buf.push_back(any_char());
			end
			default: begin
				add_text("AT+K");
				line_buf.push_back(any_char());
			end
		endcase
		add_hex(ndigits);
	endtask

	// One item, with an optional idle burst ahead of it; valid stays high afterwards
	task automatic send_char(input logic [7:0] b);
		if (idling_on && $urandom_range(0, 4) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		in_byte <= b;
		@(posedge clk);
		while (byte_stall) @(posedge clk);
		sent_chars++;
	endtask

	task automatic send_line();
		foreach (line_buf[i]) send_char(line_buf[i]);
		send_char(CH_NL);
		line_buf.delete();
	endtask

	task automatic send_text(input string s);
		add_text(s);
		send_line();
	endtask

	initial begin
		int sel;
		int idx;
		int random_start;
		cred_t which;
		logic [7:0] b;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines
		send_text("AT?");
		send_text("AT+S");
		send_text("");
		send_text("AT+D");
		send_text("AT+D=");
		send_text("AT+D=0123456789abcdef");
		send_text("AT+A:FFFFFFFFFFFFFFFF");
		send_text("AT+A");
		send_text("AT+K=0123456789ABCDEFfedcba9876543210");
		send_text("AT+S");
		send_text("AT?x");
		send_text("AT+Sx");
		send_text("AT+D=0123456789abcdeg");
		send_text("AT+Dx0123456789abcdef");
		add_cred(CRED_KEY, 65);
		send_line();
		send_text("AT+D=0000000000000000");
		send_text("XT?");
		send_text("AT+S");

		// Random lines, mostly well formed
		random_start = sent_chars;
		while (sent_chars - random_start < RANDOM_CHARS) begin
			if (sent_chars - random_start >= RANDOM_CHARS - QUIET_TAIL) idling_on = 1'b0;
			else idling_on = ($urandom_range(0, 3) != 0);
			which = cred_t'($urandom_range(0, 2));
			sel = $urandom_range(0, 99);
			if (sel < 18) begin
				add_cred(CRED_DEV, 16);
			end else if (sel < 32) begin
				add_cred(CRED_APP, 16);
			end else if (sel < 50) begin
				add_cred(CRED_KEY, 32);
			end else if (sel < 57) begin
				add_text("AT+S");
			end else if (sel < 61) begin
				add_text("AT?");
			end else if (sel < 68) begin
				// random digit count, mostly wrong
				add_cred(which, $urandom_range(0, 40));
			end else if (sel < 76) begin
				// one non-hex character in the digits
				add_cred(which, which == CRED_KEY ? 32 : 16);
				idx = $urandom_range(5, line_buf.size() - 1);
				do b = 8'($urandom_range(0, 255));
				while (b == CH_NL || (b >= "0" && b <= "9") || (b >= "A" && b <= "F")
					|| (b >= "a" && b <= "f"));
				line_buf[idx] = b;
			end else if (sel < 82) begin
				// damaged prefix
				add_cred(which, which == CRED_KEY ? 32 : 16);
				line_buf[$urandom_range(0, 4)] = any_char();
			end else if (sel < 86) begin
				// long line, position saturates
				add_cred(which, $urandom_range(59, 75));
			end else if (sel < 90) begin
				if ($urandom_range(0, 1)) add_text("AT?");
				else add_text("AT+S");
				repeat ($urandom_range(1, 3)) line_buf.push_back(any_char());
			end else if (sel < 94) begin
				// device line without the equals sign
				add_text("AT+D");
				b = any_char();
				line_buf.push_back(b == CH_EQ ? CH_S : b);
				add_hex(16);
			end else begin
				// raw noise, newlines included
				repeat ($urandom_range(0, 12)) line_buf.push_back(8'($urandom_range(0, 255)));
			end
			send_line();
		end

		// Drain
		byte_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
